>>> rtl/fce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fce_pkg: shared types and constants
// Field widths, register codes, fixed-point constants and the CORDIC
// arctangent table of the fingertip contact estimator.
// ----------------------------------------------------------------------------
package fce_pkg;

  localparam int NUM_FINGERS  = 3;
  localparam int CORDIC_STEPS = 24;

  localparam int FINGER_W  = 2;
  localparam int FORCE_W   = 32;
  localparam int SPAN_W    = 20;
  localparam int THR_W     = 31;
  localparam int CLIM_W    = 20;
  localparam int MAG_W     = 32;
  localparam int PT_W      = 16;
  localparam int STF_W     = 32;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_FORCE_LIMIT = 2'd1,
    CFG_COMP_LIMIT  = 2'd2,
    CFG_RECALIBRATE = 2'd3
  } cfg_idx_e;

  localparam logic [THR_W-1:0]  THRESHOLD_RST   = 31'd13763;
  localparam logic [THR_W-1:0]  FORCE_LIMIT_RST = 31'd655360;
  localparam logic [CLIM_W-1:0] COMP_LIMIT_RST  = 20'd5243;

  // datapath widths
  localparam int DIFF_W = FORCE_W + 1;   // raw minus offset
  localparam int CW     = 40;            // CORDIC x / y
  localparam int ZW     = 36;            // CORDIC angle, Q30 radians
  localparam int MUL_W  = 36;            // serial multiplier operand
  localparam int SUM_W  = 2 * FORCE_W + 2;
  localparam int RAD_W  = 64;            // square root radicand
  localparam int ROOT_W = RAD_W / 2;
  localparam int SPR_W  = SPAN_W + 1;    // root of span^2 + base^2
  localparam int DIV_W  = MAG_W + 12;    // magnitude * 4096
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int CS_IW  = $clog2(CORDIC_STEPS);

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic [MUL_W-1:0]     INV_GAIN    = 36'd652032874;
  localparam longint ROT_START_L = (longint'(15729) * longint'(65536) *
                                    longint'(652032874)) >>> 30;
  localparam logic signed [CW-1:0] ROT_START   = CW'(ROT_START_L);
  localparam logic [RAD_W-1:0]     BASE_SQ     = 64'd1197367609;
  localparam int                   MIN_COMP    = 104;
  localparam int                   PT_LIMIT    = 16384;

  function automatic logic signed [ZW-1:0] atan_step(input logic [CS_IW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 36'sd843314857;
      1: r = 36'sd497837829;
      2: r = 36'sd263043837;
      3: r = 36'sd133525159;
      4: r = 36'sd67021687;
      5: r = 36'sd33543516;
      6: r = 36'sd16775851;
      7: r = 36'sd8388437;
      8: r = 36'sd4194283;
      9: r = 36'sd2097149;
      default: r = (int'(i) <= 30) ? (ZW'(1) << (30 - int'(i))) : '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/fce_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fce_if: sample and result channels
// Valid/ready channels carrying one force sample and one contact result.
// ----------------------------------------------------------------------------
interface fce_in_if;
  logic                                valid;
  logic                                ready;
  logic        [fce_pkg::FINGER_W-1:0] finger;
  logic signed [fce_pkg::FORCE_W-1:0]  force_x;
  logic signed [fce_pkg::FORCE_W-1:0]  force_y;
  logic signed [fce_pkg::FORCE_W-1:0]  force_z;
  logic        [fce_pkg::SPAN_W-1:0]   span;
  logic                                span_valid;

  modport source (output valid, finger, force_x, force_y, force_z, span, span_valid,
                  input ready);
  modport sink   (input valid, finger, force_x, force_y, force_z, span, span_valid,
                  output ready);
endinterface

interface fce_out_if;
  logic                                valid;
  logic                                ready;
  logic        [fce_pkg::FINGER_W-1:0] finger_out;
  logic        [fce_pkg::MAG_W-1:0]    magnitude;
  logic                                in_contact;
  logic signed [fce_pkg::PT_W-1:0]     point_x;
  logic signed [fce_pkg::PT_W-1:0]     point_y;
  logic signed [fce_pkg::PT_W-1:0]     point_z;
  logic                                stiffness_valid;
  logic        [fce_pkg::STF_W-1:0]    stiffness;

  modport source (output valid, finger_out, magnitude, in_contact, point_x, point_y,
                  point_z, stiffness_valid, stiffness, input ready);
  modport sink   (input valid, finger_out, magnitude, in_contact, point_x, point_y,
                  point_z, stiffness_valid, stiffness, output ready);
endinterface
`default_nettype wire

>>> rtl/fingertip_contact_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fingertip_contact_estimator: force magnitude, contact point and stiffness
// Sequencer around a bit-serial multiplier, a two-bit-per-cycle square root,
// a bit-serial divider and a one-iteration-per-cycle CORDIC.
// ----------------------------------------------------------------------------
//  channel    | dir | handshake           | payload
//  -----------+-----+---------------------+-------------------------------------
//  items_i    | in  | valid / ready       | finger, force_x/y/z, span, span_valid
//  results_o  | out | valid / ready       | finger_out, magnitude, in_contact,
//             |     |                     | point_x/y/z, stiffness_valid/stiffness
//  cfg_*_i    | in  | write enable        | register index, data
//
//  One sample at a time. Magnitude takes three serial squares and a root.
//  Contact adds four CORDIC runs and two serial multiplies; a thumb
//  stiffness update adds two squares, two roots and a divide.
//  Reset clears the offsets, flags and stored points at once.
//  The next sample is taken while the last result waits in the output register.
// ----------------------------------------------------------------------------
module fingertip_contact_estimator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fce_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fce_pkg::CFG_W-1:0]       cfg_data_i,
  fce_in_if.sink                          items_i,
  fce_out_if.source                       results_o
);
  import fce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_SQ_SETUP, S_SQ_ACC, S_MAG_SETUP, S_MAG, S_DECIDE,
    S_V1_SETUP, S_H_SETUP, S_V2_SETUP, S_R1_SETUP, S_S_SETUP, S_R2_SETUP,
    S_POINT, S_STIFF, S_SP1_ADD, S_SP2_SETUP, S_SP2_ADD, S_GATE, S_DIVDONE,
    S_DONE, S_MUL, S_SQRT, S_CORD, S_DIV
  } state_e;

  state_e state_q, ret_q;

  logic [THR_W-1:0]  thr_q, flim_q;
  logic [CLIM_W-1:0] clim_q;
  logic              recal_q;

  logic        [FINGER_W-1:0] f_q;
  logic signed [FORCE_W-1:0]  raw_q [3];
  logic        [SPAN_W-1:0]   span_q;
  logic                       sv_q;

  logic signed [FORCE_W-1:0] offs_q [NUM_FINGERS][3];
  logic                      flags_q [NUM_FINGERS];
  logic signed [PT_W-1:0]    pts_q [NUM_FINGERS][3];
  logic                      span_rec_q, feat_v_q;
  logic [SPAN_W-1:0]         init_span_q;
  logic [STF_W-1:0]          feat_val_q;

  logic signed [DIFF_W-1:0] d_q [3];
  logic [1:0]               k_q;
  logic [SUM_W-1:0]         sum_q;
  logic [MAG_W-1:0]         mag_q;

  logic [MUL_W-1:0]   mul_a_q;
  logic [2*MUL_W-1:0] mul_p_q;

  logic [RAD_W-1:0]  sq_val_q;
  logic [ROOT_W+1:0] sq_rem_q;
  logic [ROOT_W-1:0] sq_root_q;

  logic signed [CW-1:0] cx_q, cy_q, rx_q;
  logic signed [ZW-1:0] cz_q, phi_q;
  logic                 vect_q, skip_q, neg_q, flip_q;
  logic [SPR_W-1:0]     r1_q;

  logic [DIV_W-1:0] div_n_q;
  logic [SPR_W-1:0] div_d_q, div_r_q;

  logic [CNT_W-1:0] cnt_q;

  logic                       out_valid_q;
  logic [FINGER_W-1:0]        o_finger_q;
  logic [MAG_W-1:0]           o_mag_q;
  logic                       o_contact_q;
  logic signed [PT_W-1:0]     o_pt_q [3];
  logic                       o_sv_q;
  logic [STF_W-1:0]           o_stf_q;

  function automatic logic signed [PT_W-1:0] clamp_pt(input logic signed [CW-1:0] v);
    logic signed [PT_W-1:0] r;
    if (v > CW'(PT_LIMIT))       r = PT_W'(PT_LIMIT);
    else if (v < -CW'(PT_LIMIT)) r = -PT_W'(PT_LIMIT);
    else                         r = v[PT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [CW-1:0] round16(input logic signed [CW-1:0] v);
    return (v + CW'(1 << 15)) >>> 16;
  endfunction

  // ---- shared datapath steps ----
  logic [CS_IW-1:0]     ci;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  logic                 rot_pos;
  logic [MUL_W:0]       mul_sum;
  logic [ROOT_W+2:0]    sq_sh, sq_trial;
  logic [SPR_W:0]       div_sh;
  logic [DIFF_W-1:0]    abs_d;
  logic signed [CW-1:0] h_val, s_val, dz_ext, p_qx, p_qy;
  logic signed [2*MUL_W:0] prod_s;
  logic signed [SPR_W+1:0] comp;
  logic                    gate;

  always_comb begin
    ci      = cnt_q[CS_IW-1:0];
    xs      = cx_q >>> ci;
    ys      = cy_q >>> ci;
    at      = atan_step(ci);
    rot_pos = vect_q ? cy_q[CW-1] : !cz_q[ZW-1];
    mul_sum = {1'b0, mul_p_q[2*MUL_W-1:MUL_W]} + (mul_p_q[0] ? {1'b0, mul_a_q} : '0);
    sq_sh    = {sq_rem_q[ROOT_W:0], sq_val_q[RAD_W-1:RAD_W-2]};
    sq_trial = {1'b0, sq_root_q, 2'b01};
    div_sh   = {div_r_q, div_n_q[DIV_W-1]};
    abs_d    = d_q[k_q][DIFF_W-1] ? DIFF_W'(-d_q[k_q]) : DIFF_W'(d_q[k_q]);
    h_val    = CW'(mul_p_q[CW+29:30]);
    prod_s   = neg_q ? -$signed({1'b0, mul_p_q}) : $signed({1'b0, mul_p_q});
    s_val    = CW'(prod_s >>> 30);
    dz_ext   = CW'(d_q[2]);
    p_qx     = flip_q ? -round16(cx_q) : round16(cx_q);
    p_qy     = flip_q ? -round16(cy_q) : round16(cy_q);
    comp     = $signed({1'b0, r1_q}) - $signed({1'b0, sq_root_q[SPR_W-1:0]});
    gate     = ((mag_q >= {1'b0, flim_q}) || (comp >= $signed({2'b00, clim_q}))) &&
               (comp > (SPR_W+2)'(MIN_COMP));
  end

  assign items_i.ready             = (state_q == S_IDLE);
  assign results_o.valid           = out_valid_q;
  assign results_o.finger_out      = o_finger_q;
  assign results_o.magnitude       = o_mag_q;
  assign results_o.in_contact      = o_contact_q;
  assign results_o.point_x         = o_pt_q[0];
  assign results_o.point_y         = o_pt_q[1];
  assign results_o.point_z         = o_pt_q[2];
  assign results_o.stiffness_valid = o_sv_q;
  assign results_o.stiffness       = o_stf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      thr_q       <= THRESHOLD_RST;
      flim_q      <= FORCE_LIMIT_RST;
      clim_q      <= COMP_LIMIT_RST;
      recal_q     <= 1'b0;
      f_q         <= '0;
      raw_q       <= '{default: '0};
      span_q      <= '0;
      sv_q        <= 1'b0;
      offs_q      <= '{default: '{default: '0}};
      flags_q     <= '{default: 1'b0};
      pts_q       <= '{default: '{default: '0}};
      span_rec_q  <= 1'b0;
      feat_v_q    <= 1'b0;
      init_span_q <= '0;
      feat_val_q  <= '0;
      d_q         <= '{default: '0};
      k_q         <= '0;
      sum_q       <= '0;
      mag_q       <= '0;
      mul_a_q     <= '0;
      mul_p_q     <= '0;
      sq_val_q    <= '0;
      sq_rem_q    <= '0;
      sq_root_q   <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      rx_q        <= '0;
      phi_q       <= '0;
      vect_q      <= 1'b0;
      skip_q      <= 1'b0;
      neg_q       <= 1'b0;
      flip_q      <= 1'b0;
      r1_q        <= '0;
      div_n_q     <= '0;
      div_d_q     <= '0;
      div_r_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      o_finger_q  <= '0;
      o_mag_q     <= '0;
      o_contact_q <= 1'b0;
      o_pt_q      <= '{default: '0};
      o_sv_q      <= 1'b0;
      o_stf_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_THRESHOLD:   thr_q   <= cfg_data_i[THR_W-1:0];
          CFG_FORCE_LIMIT: flim_q  <= cfg_data_i[THR_W-1:0];
          CFG_COMP_LIMIT:  clim_q  <= cfg_data_i[CLIM_W-1:0];
          CFG_RECALIBRATE: recal_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      // S_DONE reloads the output register itself
      if (out_valid_q && results_o.ready && state_q != S_DONE) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (items_i.valid && items_i.finger < FINGER_W'(NUM_FINGERS)) begin
            f_q      <= items_i.finger;
            raw_q[0] <= items_i.force_x;
            raw_q[1] <= items_i.force_y;
            raw_q[2] <= items_i.force_z;
            span_q   <= items_i.span;
            sv_q     <= items_i.span_valid;
            state_q  <= S_DIFF;
          end
        end
        S_DIFF: begin
          for (int k = 0; k < 3; k++) begin
            d_q[k] <= DIFF_W'(raw_q[k]) - DIFF_W'(offs_q[f_q][k]);
          end
          k_q     <= '0;
          sum_q   <= '0;
          state_q <= S_SQ_SETUP;
        end
        S_SQ_SETUP: begin
          mul_a_q <= MUL_W'(abs_d);
          mul_p_q <= {{MUL_W{1'b0}}, MUL_W'(abs_d)};
          cnt_q   <= '0;
          ret_q   <= S_SQ_ACC;
          state_q <= S_MUL;
        end
        S_SQ_ACC: begin
          sum_q <= sum_q + {2'b00, mul_p_q[RAD_W-1:0]};
          k_q   <= k_q + 2'd1;
          state_q <= (k_q == 2'd2) ? S_MAG_SETUP : S_SQ_SETUP;
        end
        S_MAG_SETUP: begin
          if (sum_q[SUM_W-1:RAD_W] != '0) begin
            mag_q   <= '1;
            state_q <= S_DECIDE;
          end else begin
            sq_val_q  <= sum_q[RAD_W-1:0];
            sq_rem_q  <= '0;
            sq_root_q <= '0;
            cnt_q     <= '0;
            ret_q     <= S_MAG;
            state_q   <= S_SQRT;
          end
        end
        S_MAG: begin
          mag_q   <= sq_root_q;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (recal_q) begin
            offs_q[f_q]  <= raw_q;
            flags_q[f_q] <= 1'b0;
            if (f_q == '0) begin
              feat_v_q   <= 1'b0;
              span_rec_q <= 1'b0;
            end
            state_q <= S_DONE;
          end else begin
            flags_q[f_q] <= (mag_q > {1'b0, thr_q});
            if (mag_q > {1'b0, thr_q}) state_q <= S_V1_SETUP;
            else if (f_q == '0)        state_q <= S_STIFF;
            else                       state_q <= S_DONE;
          end
        end
        S_V1_SETUP: begin
          if (!d_q[0][DIFF_W-1]) begin
            cx_q <= CW'(d_q[0]);
            cy_q <= CW'(d_q[1]);
            cz_q <= d_q[1][DIFF_W-1] ? PI_Q30 : -PI_Q30;
          end else begin
            cx_q <= -CW'(d_q[0]);
            cy_q <= -CW'(d_q[1]);
            cz_q <= '0;
          end
          skip_q  <= (d_q[0] == '0) && (d_q[1] == '0);
          vect_q  <= 1'b1;
          cnt_q   <= '0;
          ret_q   <= S_H_SETUP;
          state_q <= S_CORD;
        end
        S_H_SETUP: begin
          phi_q   <= cz_q;
          mul_a_q <= cx_q[CW-1] ? '0 : MUL_W'(cx_q);
          mul_p_q <= {{MUL_W{1'b0}}, INV_GAIN};
          cnt_q   <= '0;
          ret_q   <= S_V2_SETUP;
          state_q <= S_MUL;
        end
        S_V2_SETUP: begin
          if (!dz_ext[CW-1]) begin
            cx_q <= dz_ext;
            cy_q <= -h_val;
            cz_q <= PI_Q30;
          end else begin
            cx_q <= -dz_ext;
            cy_q <= h_val;
            cz_q <= '0;
          end
          skip_q  <= (dz_ext == '0) && (h_val == '0);
          vect_q  <= 1'b1;
          cnt_q   <= '0;
          ret_q   <= S_R1_SETUP;
          state_q <= S_CORD;
        end
        S_R1_SETUP: begin
          // halve toward zero
          cz_q    <= (cz_q + (cz_q[ZW-1] ? ZW'(1) : ZW'(0))) >>> 1;
          cx_q    <= ROT_START;
          cy_q    <= '0;
          skip_q  <= 1'b0;
          vect_q  <= 1'b0;
          cnt_q   <= '0;
          ret_q   <= S_S_SETUP;
          state_q <= S_CORD;
        end
        S_S_SETUP: begin
          rx_q    <= cx_q;
          neg_q   <= cy_q[CW-1];
          mul_a_q <= cy_q[CW-1] ? MUL_W'(-cy_q) : MUL_W'(cy_q);
          mul_p_q <= {{MUL_W{1'b0}}, INV_GAIN};
          cnt_q   <= '0;
          ret_q   <= S_R2_SETUP;
          state_q <= S_MUL;
        end
        S_R2_SETUP: begin
          cx_q <= s_val;
          cy_q <= '0;
          if (phi_q > HALF_PI_Q30) begin
            cz_q   <= phi_q - PI_Q30;
            flip_q <= 1'b1;
          end else if (phi_q < -HALF_PI_Q30) begin
            cz_q   <= phi_q + PI_Q30;
            flip_q <= 1'b1;
          end else begin
            cz_q   <= phi_q;
            flip_q <= 1'b0;
          end
          skip_q  <= 1'b0;
          vect_q  <= 1'b0;
          cnt_q   <= '0;
          ret_q   <= S_POINT;
          state_q <= S_CORD;
        end
        S_POINT: begin
          pts_q[f_q][0] <= clamp_pt(round16(rx_q));
          pts_q[f_q][1] <= clamp_pt(p_qx);
          pts_q[f_q][2] <= clamp_pt(p_qy);
          state_q <= (f_q == '0) ? S_STIFF : S_DONE;
        end
        S_STIFF: begin
          if (!(flags_q[0] && flags_q[1] && flags_q[2])) begin
            span_rec_q <= 1'b0;
            feat_v_q   <= 1'b0;
            state_q    <= S_DONE;
          end else if (!span_rec_q) begin
            span_rec_q <= 1'b1;
            if (sv_q) init_span_q <= span_q;
            state_q <= S_DONE;
          end else if (sv_q) begin
            mul_a_q <= MUL_W'(init_span_q);
            mul_p_q <= {{MUL_W{1'b0}}, MUL_W'(init_span_q)};
            cnt_q   <= '0;
            ret_q   <= S_SP1_ADD;
            state_q <= S_MUL;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_SP1_ADD: begin
          sq_val_q  <= mul_p_q[RAD_W-1:0] + BASE_SQ;
          sq_rem_q  <= '0;
          sq_root_q <= '0;
          cnt_q     <= '0;
          ret_q     <= S_SP2_SETUP;
          state_q   <= S_SQRT;
        end
        S_SP2_SETUP: begin
          r1_q    <= sq_root_q[SPR_W-1:0];
          mul_a_q <= MUL_W'(span_q);
          mul_p_q <= {{MUL_W{1'b0}}, MUL_W'(span_q)};
          cnt_q   <= '0;
          ret_q   <= S_SP2_ADD;
          state_q <= S_MUL;
        end
        S_SP2_ADD: begin
          sq_val_q  <= mul_p_q[RAD_W-1:0] + BASE_SQ;
          sq_rem_q  <= '0;
          sq_root_q <= '0;
          cnt_q     <= '0;
          ret_q     <= S_GATE;
          state_q   <= S_SQRT;
        end
        S_GATE: begin
          if (gate) begin
            div_n_q <= {mag_q, 12'b0};
            div_d_q <= comp[SPR_W-1:0];
            div_r_q <= '0;
            cnt_q   <= '0;
            ret_q   <= S_DIVDONE;
            state_q <= S_DIV;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DIVDONE: begin
          feat_v_q   <= 1'b1;
          feat_val_q <= (div_n_q[DIV_W-1:STF_W] != '0) ? '1 : div_n_q[STF_W-1:0];
          state_q    <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || results_o.ready) begin
            out_valid_q <= 1'b1;
            o_finger_q  <= f_q;
            o_mag_q     <= mag_q;
            o_contact_q <= flags_q[f_q];
            o_pt_q      <= pts_q[f_q];
            o_sv_q      <= feat_v_q;
            o_stf_q     <= feat_v_q ? feat_val_q : '0;
            state_q     <= S_IDLE;
          end
        end
        S_MUL: begin
          mul_p_q <= {mul_sum, mul_p_q[MUL_W-1:1]};
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(MUL_W-1)) state_q <= ret_q;
        end
        S_SQRT: begin
          if (sq_sh >= sq_trial) begin
            sq_rem_q  <= (ROOT_W+2)'(sq_sh - sq_trial);
            sq_root_q <= {sq_root_q[ROOT_W-2:0], 1'b1};
          end else begin
            sq_rem_q  <= (ROOT_W+2)'(sq_sh);
            sq_root_q <= {sq_root_q[ROOT_W-2:0], 1'b0};
          end
          sq_val_q <= {sq_val_q[RAD_W-3:0], 2'b00};
          cnt_q    <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(ROOT_W-1)) state_q <= ret_q;
        end
        S_CORD: begin
          if (skip_q) begin
            state_q <= ret_q;
          end else begin
            if (rot_pos) begin
              cx_q <= cx_q - ys;
              cy_q <= cy_q + xs;
              cz_q <= cz_q - at;
            end else begin
              cx_q <= cx_q + ys;
              cy_q <= cy_q - xs;
              cz_q <= cz_q + at;
            end
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CNT_W'(CORDIC_STEPS-1)) state_q <= ret_q;
          end
        end
        S_DIV: begin
          if (div_sh >= {1'b0, div_d_q}) begin
            div_r_q <= SPR_W'(div_sh - {1'b0, div_d_q});
            div_n_q <= {div_n_q[DIV_W-2:0], 1'b1};
          end else begin
            div_r_q <= div_sh[SPR_W-1:0];
            div_n_q <= {div_n_q[DIV_W-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_W-1)) state_q <= ret_q;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/fce_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fce_checker: port-level checks on the contact estimator
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module fce_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [fce_pkg::FINGER_W-1:0] finger_out_i,
  input logic [fce_pkg::MAG_W-1:0]    magnitude_i,
  input logic                         in_contact_i,
  input logic                         stiffness_valid_i,
  input logic [fce_pkg::STF_W-1:0]    stiffness_i
);
  import fce_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_finger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> finger_out_i != FINGER_W'(NUM_FINGERS))
    else $error("result for unused finger index");

  a_stf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !stiffness_valid_i |-> stiffness_i == '0)
    else $error("stiffness nonzero while invalid");

  a_contact_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && in_contact_i |-> magnitude_i != '0)
    else $error("contact with zero magnitude");

endmodule

bind fingertip_contact_estimator fce_checker u_fce_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (results_o.valid),
  .out_ready_i       (results_o.ready),
  .finger_out_i      (results_o.finger_out),
  .magnitude_i       (results_o.magnitude),
  .in_contact_i      (results_o.in_contact),
  .stiffness_valid_i (results_o.stiffness_valid),
  .stiffness_i       (results_o.stiffness)
);
`default_nettype wire

>>> sim/tb_fingertip_contact_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_fingertip_contact_estimator: self-checking bench for the contact estimator
// Drives force samples through the valid/ready channels with random gaps and
// stalls. Expected magnitude, contact point and stiffness come from a
// bit-accurate predictor kept in a scoreboard class. Results are compared in
// order.
// ----------------------------------------------------------------------------
module tb_fingertip_contact_estimator;
  import fce_pkg::*;

  typedef struct {
    bit        [1:0]  finger;
    bit signed [31:0] fx, fy, fz;
    bit        [19:0] span;
    bit               span_valid;
  } sample_t;

  typedef struct {
    bit        [1:0]  finger;
    bit        [31:0] magnitude;
    bit               in_contact;
    bit signed [15:0] px, py, pz;
    bit               stiff_valid;
    bit        [31:0] stiffness;
  } contact_t;

  localparam longint PI_L       = 64'sd3373259426;
  localparam longint INV_K      = 64'sd652032874;
  localparam longint ROT_INIT   = (longint'(15729) * 65536 * INV_K) >>> 30;
  localparam longint BASE_L     = 34603;
  localparam longint MIN_COMP_L = 104;
  localparam int     NUM_STEPS  = 24;
  localparam int     SETTLE_CYC = 800;
  localparam int     CYCLE_CAP  = 6000000;

  class contact_scoreboard;
    bit [30:0] threshold, force_lim;
    bit [19:0] comp_lim;
    bit        recal;
    bit signed [31:0] offsets[9];
    bit        touching[3];
    bit        span_seen, stiff_ok;
    bit [19:0] first_span;
    bit [31:0] stiff_val;
    longint    points[3][3];
    contact_t  pending[$];
    int        errors;

    function new();
      threshold = THRESHOLD_RST;
      force_lim = FORCE_LIMIT_RST;
      comp_lim  = COMP_LIMIT_RST;
      recal     = 1'b0;
      foreach (offsets[k]) offsets[k] = '0;
      foreach (touching[k]) touching[k] = 1'b0;
      foreach (points[k, j]) points[k][j] = 0;
      span_seen = 0; stiff_ok = 0; first_span = '0; stiff_val = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, bit [30:0] data);
      case (idx)
        CFG_THRESHOLD:   threshold = data;
        CFG_FORCE_LIMIT: force_lim = data;
        CFG_COMP_LIMIT:  comp_lim  = data[19:0];
        CFG_RECALIBRATE: recal     = data[0];
      endcase
    endfunction

    function bit [63:0] floor_sqrt(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint arctan_q30(int i);
      case (i)
        0: return 843314857;
        1: return 497837829;
        2: return 263043837;
        3: return 133525159;
        4: return 67021687;
        5: return 33543516;
        6: return 16775851;
        7: return 8388437;
        8: return 4194283;
        9: return 2097149;
        default: return (i <= 30) ? (longint'(1) << (30 - i)) : 0;
      endcase
    endfunction

    function void rotate(ref longint x, ref longint y, ref longint z, input bit vectoring);
      longint xs, ys, a;
      bit     pos;
      if (vectoring && x == 0 && y == 0) return;
      for (int i = 0; i < NUM_STEPS; i++) begin
        xs  = x >>> i;
        ys  = y >>> i;
        a   = arctan_q30(i);
        pos = vectoring ? (y < 0) : (z >= 0);
        if (pos) begin
          x = x - ys; y = y + xs; z = z - a;
        end else begin
          x = x + ys; y = y - xs; z = z + a;
        end
      end
    endfunction

    function longint clip_point(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
    endfunction

    // place the contact on the hemispherical pad from the corrected force
    function void locate_contact(longint d[3], int f);
      longint vx, vy, phi, h, ax, ay, theta, rx, ry, rz, s, qx, qy;
      bit [63:0] prod;
      bit flip;
      vx = -d[0]; vy = -d[1]; phi = 0; theta = 0; flip = 0;
      if (d[0] >= 0) begin
        vx = d[0]; vy = d[1];
        phi = (d[1] >= 0) ? -PI_L : PI_L;
      end
      rotate(vx, vy, phi, 1'b1);
      prod = 64'(vx) * 64'(INV_K);
      h = (vx < 0) ? 0 : longint'(prod >> 30);
      ax = -d[2]; ay = h;
      if (d[2] >= 0) begin
        ax = d[2]; ay = -h; theta = PI_L;
      end
      rotate(ax, ay, theta, 1'b1);
      rx = ROT_INIT; ry = 0; rz = theta / 2;
      rotate(rx, ry, rz, 1'b0);
      s = (ry * INV_K) >>> 30;
      if (phi > PI_L / 2) begin
        phi -= PI_L; flip = 1;
      end else if (phi < -(PI_L / 2)) begin
        phi += PI_L; flip = 1;
      end
      qx = s; qy = 0;
      rotate(qx, qy, phi, 1'b0);
      qx = (qx + 32768) >>> 16;
      qy = (qy + 32768) >>> 16;
      if (flip) begin
        qx = -qx; qy = -qy;
      end
      points[f][0] = clip_point((rx + 32768) >>> 16);
      points[f][1] = clip_point(qx);
      points[f][2] = clip_point(qy);
    endfunction

    function void grasp_update(bit [31:0] mag, bit [19:0] span, bit span_ok);
      longint c;
      bit [63:0] q;
      if (!(touching[0] && touching[1] && touching[2])) begin
        span_seen = 0; stiff_ok = 0;
        return;
      end
      if (!span_seen) begin
        span_seen = 1;
        if (span_ok) first_span = span;
      end else if (span_ok) begin
        c = longint'(floor_sqrt(64'(first_span) * first_span + BASE_L * BASE_L))
          - longint'(floor_sqrt(64'(span) * span + BASE_L * BASE_L));
        if ((mag >= force_lim || c >= longint'(comp_lim)) && c > MIN_COMP_L) begin
          q = (64'(mag) << 12) / 64'(c);
          stiff_ok  = 1;
          stiff_val = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        end
      end
    endfunction

    function void note_sample(sample_t s);
      longint    d[3];
      bit [63:0] sum, sq, a;
      bit [31:0] mag;
      bit        sat;
      contact_t  e;
      int        f;
      if (s.finger == 2'd3) return;
      f = s.finger;
      sum = 0; sat = 0;
      d[0] = longint'(s.fx) - longint'(offsets[f*3]);
      d[1] = longint'(s.fy) - longint'(offsets[f*3+1]);
      d[2] = longint'(s.fz) - longint'(offsets[f*3+2]);
      for (int k = 0; k < 3; k++) begin
        a  = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
        sq = a * a;
        if (sum + sq < sum) sat = 1;
        sum += sq;
      end
      mag = sat ? 32'hFFFF_FFFF : 32'(floor_sqrt(sum));
      if (recal) begin
        offsets[f*3] = s.fx; offsets[f*3+1] = s.fy; offsets[f*3+2] = s.fz;
        touching[f] = 0;
        if (f == 0) begin
          stiff_ok = 0; span_seen = 0;
        end
      end else begin
        touching[f] = (mag > {1'b0, threshold});
        if (touching[f]) locate_contact(d, f);
        if (f == 0) grasp_update(mag, s.span, s.span_valid);
      end
      e.finger      = s.finger;
      e.magnitude   = mag;
      e.in_contact  = touching[f];
      e.px          = 16'(points[f][0]);
      e.py          = 16'(points[f][1]);
      e.pz          = 16'(points[f][2]);
      e.stiff_valid = stiff_ok;
      e.stiffness   = stiff_ok ? stiff_val : '0;
      pending.push_back(e);
    endfunction

    function void compare(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(contact_t r);
      contact_t e;
      if (pending.size() == 0) begin
        $error("result for finger %0d with nothing outstanding", r.finger);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare("finger_out", e.finger, r.finger);
      compare("magnitude", e.magnitude, r.magnitude);
      compare("in_contact", e.in_contact, r.in_contact);
      compare("point_x", e.px, r.px);
      compare("point_y", e.py, r.py);
      compare("point_z", e.pz, r.pz);
      compare("stiffness_valid", e.stiff_valid, r.stiff_valid);
      compare("stiffness", e.stiffness, r.stiffness);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  fce_in_if  items_if ();
  fce_out_if results_if ();

  fingertip_contact_estimator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .items_i    (items_if.sink),
    .results_o  (results_if.source)
  );

  contact_scoreboard grasp_sb = new();
  int send_gap_pct;
  int recv_stall_pct;
  int cycles = 0;

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // sample both channels on the edge at which a transfer happens
  always @(posedge clk_i) begin
    contact_t r;
    if (rst_ni && items_if.valid && items_if.ready) begin
      grasp_sb.note_sample('{items_if.finger, items_if.force_x, items_if.force_y,
                             items_if.force_z, items_if.span, items_if.span_valid});
    end
    if (rst_ni && results_if.valid && results_if.ready) begin
      r.finger      = results_if.finger_out;
      r.magnitude   = results_if.magnitude;
      r.in_contact  = results_if.in_contact;
      r.px          = results_if.point_x;
      r.py          = results_if.point_y;
      r.pz          = results_if.point_z;
      r.stiff_valid = results_if.stiffness_valid;
      r.stiffness   = results_if.stiffness;
      grasp_sb.check_result(r);
    end
  end

  task automatic send_sample(sample_t s);
    if ($urandom_range(99) < send_gap_pct) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    items_if.valid      <= 1'b1;
    items_if.finger     <= s.finger;
    items_if.force_x    <= s.fx;
    items_if.force_y    <= s.fy;
    items_if.force_z    <= s.fz;
    items_if.span       <= s.span;
    items_if.span_valid <= s.span_valid;
    @(posedge clk_i);
    while (!items_if.ready) @(posedge clk_i);
  endtask

  task automatic send(bit [1:0] f, int x, int y, int z, bit [19:0] sp = 0, bit spv = 0);
    sample_t s;
    s = '{f, x, y, z, sp, spv};
    send_sample(s);
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic drain();
    items_if.valid <= 1'b0;
    @(posedge clk_i);
    while (grasp_sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [30:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    grasp_sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  function automatic int small_force(int lim);
    return $urandom_range(2 * lim) - lim;
  endfunction

  // all three pads pressed, then the thumb closes in on a shrinking span
  task automatic grasp_sequence();
    int s0;
    s0 = $urandom_range(20000, 400000);
    send(2'd1, small_force(1 << 18), small_force(1 << 18), small_force(1 << 18));
    send(2'd2, small_force(1 << 18), small_force(1 << 18), small_force(1 << 18));
    repeat ($urandom_range(2, 6)) begin
      s0 = s0 - $urandom_range(0, 30000);
      if (s0 < 0) s0 = 0;
      send(2'd0, small_force(1 << 19), small_force(1 << 19), small_force(1 << 19),
           20'(s0), $urandom_range(99) < 85);
    end
  endtask

  task automatic noise_sample();
    sample_t s;
    s.finger     = ($urandom_range(99) < 6) ? 2'd3 : 2'($urandom_range(2));
    s.span       = 20'($urandom);
    s.span_valid = $urandom_range(1);
    case ($urandom_range(4))
      0: begin s.fx = $urandom; s.fy = $urandom; s.fz = $urandom; end
      1: begin s.fx = 0; s.fy = small_force(1 << 16); s.fz = small_force(1 << 16); end
      2: begin s.fx = small_force(1 << 16); s.fy = 0; s.fz = 0; end
      default: begin
        s.fx = small_force(1 << 17); s.fy = small_force(1 << 17);
        s.fz = small_force(1 << 17);
      end
    endcase
    send_sample(s);
  endtask

  task automatic recalibrate_all(bit wide);
    write_reg(CFG_RECALIBRATE, 31'd1);
    for (int f = 0; f < 3; f++) begin
      if (wide) send(2'(f), $urandom, $urandom, $urandom);
      else send(2'(f), small_force(1 << 14), small_force(1 << 14), small_force(1 << 14));
    end
    drain();
    write_reg(CFG_RECALIBRATE, 31'd0);
  endtask

  initial begin
    int sent;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    items_if.valid = 1'b0;
    items_if.finger = '0;
    items_if.force_x = '0;
    items_if.force_y = '0;
    items_if.force_z = '0;
    items_if.span = '0;
    items_if.span_valid = 1'b0;
    results_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero components, ignored finger, grasp with missing span
    send(2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(2'd2, 0, 0, 0);
    send(2'd3, 1000, 1000, 1000);
    send(2'd1, 0, 0, -100000);
    send(2'd2, 0, 0, 100000);
    send(2'd1, 0, -70000, 0);
    send(2'd2, -70000, 0, 5000);
    send(2'd0, 200000, 0, 0, 20'd200000, 1'b0);
    send(2'd0, 200000, 1000, -300000, 20'd150000, 1'b1);
    send(2'd0, 300000, -2000, -300000, 20'd20000, 1'b1);
    send(2'd0, 50000, 50000, 50000, 20'hFFFFF, 1'b1);
    drain();
    write_reg(CFG_THRESHOLD, 31'd0);
    send(2'd0, 0, 0, 1, 20'd0, 1'b1);
    send(2'd1, 1, 0, 0);
    send(2'd2, 0, -1, 0);
    drain();
    write_reg(CFG_RECALIBRATE, 31'd1);
    send(2'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    write_reg(CFG_RECALIBRATE, 31'd0);
    send(2'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(2'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    recalibrate_all(1'b0);

    for (int ph = 0; ph < 10; ph++) begin
      send_gap_pct   = (ph < 4) ? 26 : (ph < 7) ? 69 : 0;
      recv_stall_pct = (ph < 4) ? 69 : (ph < 7) ? 26 : 0;
      drain();
      case (ph)
        0: write_reg(CFG_THRESHOLD, THRESHOLD_RST);
        2: write_reg(CFG_THRESHOLD, 31'h7FFF_FFFF);
        5: write_reg(CFG_THRESHOLD, 31'd0);
        default: write_reg(CFG_THRESHOLD, 31'($urandom_range(1, 60000)));
      endcase
      case (ph % 4)
        0: write_reg(CFG_FORCE_LIMIT, FORCE_LIMIT_RST);
        1: write_reg(CFG_FORCE_LIMIT, 31'd0);
        2: write_reg(CFG_FORCE_LIMIT, 31'h7FFF_FFFF);
        default: write_reg(CFG_FORCE_LIMIT, 31'($urandom_range(0, 2000000)));
      endcase
      case (ph % 3)
        0: write_reg(CFG_COMP_LIMIT, 31'(COMP_LIMIT_RST));
        1: write_reg(CFG_COMP_LIMIT, 31'd0);
        default: write_reg(CFG_COMP_LIMIT, 31'hF_FFFF);
      endcase
      recalibrate_all(ph == 3);
      if (ph == 3) recalibrate_all(1'b0);
      sent = 0;
      while (sent < 190) begin
        if ($urandom_range(99) < 70) begin
          grasp_sequence();
          // four to eight samples, six on average
          sent += 6;
        end else begin
          noise_sample();
          sent++;
        end
      end
    end

    drain();
    if (grasp_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  final begin
  end

endmodule
`default_nettype wire
